// ----- rtl/stream_replace_first_match_defines.svh -----
// assertion macros for the stream_replace_first_match block
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef STREAM_REPLACE_FIRST_MATCH_DEFINES_SVH
`define STREAM_REPLACE_FIRST_MATCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SRFM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srfm check failed");

// next-cycle implication, checked outside reset
`define SRFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srfm check failed");

`endif

// ----- rtl/srfm_pkg.sv -----
// shared types and constants of the stream_replace_first_match block
// no dependencies
package srfm_pkg;

    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;
    localparam int RB_IW     = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = CFG_IDX_W'(3);

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_line_end;
        logic       run_last;
    } t_out_item;

    // what one input beat asks of the back end
    typedef struct packed {
        logic [CNT_W-1:0] pop_count;
        logic             rep;
        logic             line_end;
    } t_cmd_ctl;

    function automatic logic [CNT_W-1:0] sat_len(input logic [CNT_W-1:0] len,
                                                 input logic [CNT_W-1:0] max_len);
        sat_len = (len > max_len) ? max_len : len;
    endfunction

endpackage

// ----- rtl/srfm_queue.sv -----
// small register queue carrying commands from the front end to the back end
// no package dependencies
module srfm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_nempty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(DEPTH);
    localparam logic [PTR_W-1:0]  LAST_C  = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_QW-1:0] r_count;
    logic              do_push, do_pop;

    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_nempty;
    assign o_full   = (r_count == DEPTH_C);
    assign o_nempty = (r_count != '0);
    assign o_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_C) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_C) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/srfm_front.sv -----
// front end: sliding window, pattern compare, per-beat command generation
// depends on srfm_pkg
module srfm_front import srfm_pkg::*; #(
    parameter int MAX_PATTERN = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  t_in_item                 i_item,
    input  logic [CFG_DAT_W-1:0]     i_pattern_bytes,
    input  logic [CNT_W-1:0]         i_pattern_length,
    output t_cmd_ctl                 o_cmd_ctl,
    output logic [MAX_PATTERN*8-1:0] o_cmd_win
);

    localparam int WIN_W = MAX_PATTERN * 8;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MAX_PATTERN);

    logic [WIN_W-1:0]    r_win, n_win;
    logic [WIN_W-1:0]    snap;
    logic [WIN_W+15:0]   snap_ext;
    logic [CNT_W-1:0]    r_fill, n_fill;
    logic                r_done, n_done;
    logic [CNT_W-1:0]    plen, fill1, target, pops;
    logic                rep_start, rep_match, done1, room, match;

    always_comb begin
        plen      = sat_len(i_pattern_length, DEPTH_C);
        rep_start = (plen == '0) && !r_done && (r_fill == '0);
        done1     = r_done || rep_start;
        room      = (r_fill < DEPTH_C);

        // window with the new character placed behind the held ones
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (room && r_fill == CNT_W'(i)) begin
                snap[i*8 +: 8] = i_item.char_byte;
            end else begin
                snap[i*8 +: 8] = r_win[i*8 +: 8];
            end
        end
        snap_ext = {16'b0, snap};
        fill1    = r_fill + CNT_W'(room);
        target   = done1 ? '0 : plen;

        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CNT_W'(i) < plen && snap[i*8 +: 8] != i_pattern_bytes[i*8 +: 8]) begin
                match = 1'b0;
            end
        end

        pops      = '0;
        rep_match = 1'b0;
        n_fill    = fill1;
        n_done    = done1;
        if (fill1 > target) begin
            // drain at most two held characters per beat
            pops   = (fill1 > target + CNT_W'(1)) ? CNT_W'(2) : CNT_W'(1);
            n_fill = fill1 - pops;
        end else if (fill1 == plen && !done1) begin
            if (match) begin
                rep_match = 1'b1;
                n_fill    = '0;
                n_done    = 1'b1;
            end else begin
                pops   = CNT_W'(1);
                n_fill = fill1 - CNT_W'(1);
            end
        end

        case (pops)
            CNT_W'(1): n_win = snap_ext[8 +: WIN_W];
            CNT_W'(2): n_win = snap_ext[16 +: WIN_W];
            default:   n_win = snap;
        endcase

        o_cmd_ctl.rep      = rep_start || rep_match;
        o_cmd_ctl.line_end = i_item.line_end;
        o_cmd_win          = snap;
        if (i_item.line_end) begin
            // line end flushes whatever is still held
            o_cmd_ctl.pop_count = rep_match ? '0 : fill1;
            n_fill              = '0;
            n_done              = 1'b0;
        end else begin
            o_cmd_ctl.pop_count = pops;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else if (i_accept) begin
            r_fill <= n_fill;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ----- rtl/srfm_back.sv -----
// back end: walks one command per beat into results, output register
// depends on srfm_pkg
module srfm_back import srfm_pkg::*; #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_head_valid,
    input  t_cmd_ctl                 i_head_ctl,
    input  logic [MAX_PATTERN*8-1:0] i_head_win,
    input  logic [CFG_DAT_W-1:0]     i_replacement_bytes,
    input  logic [CNT_W-1:0]         i_replacement_length,
    output logic                     o_pop,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output t_out_item                o_out_item
);

    localparam int WIN_IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [CNT_W-1:0] RMAX_C = CNT_W'(MAX_REPLACEMENT);

    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] rep_len, win_idx;
    logic [CNT_W:0]   total;
    logic             out_adv, is_last, in_rep;
    logic [7:0]       sel_byte;

    assign rep_len  = i_head_ctl.rep ? sat_len(i_replacement_length, RMAX_C) : '0;
    assign total    = {1'b0, rep_len} + {1'b0, i_head_ctl.pop_count};
    assign out_adv  = !r_out_valid || !i_out_stall;
    assign is_last  = ({1'b0, r_idx} + (CNT_W+1)'(1)) == total;
    assign in_rep   = r_idx < rep_len;
    assign win_idx  = r_idx - rep_len;
    assign sel_byte = in_rep ? i_replacement_bytes[r_idx[RB_IW-1:0]*8 +: 8]
                             : i_head_win[win_idx[WIN_IW-1:0]*8 +: 8];

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_pop       = 1'b0;
        if (i_head_valid && out_adv) begin
            if (total == '0) begin
                // nothing to emit, except a bare line end
                o_pop = 1'b1;
                if (i_head_ctl.line_end) begin
                    n_out_valid        = 1'b1;
                    n_out.out_byte     = 8'd0;
                    n_out.has_byte     = 1'b0;
                    n_out.out_line_end = 1'b1;
                    n_out.run_last     = 1'b1;
                end
            end else begin
                n_out_valid        = 1'b1;
                n_out.out_byte     = sel_byte;
                n_out.has_byte     = 1'b1;
                n_out.out_line_end = is_last && i_head_ctl.line_end;
                n_out.run_last     = is_last;
                if (is_last) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/stream_replace_first_match.sv -----
// top level: config registers, front end, command queue, back end
// depends on srfm_pkg, srfm_queue, srfm_front, srfm_back and the defines header
//
//  channel   direction  handshake                 beat
//  in        input      i_in_valid / o_in_stall   t_in_item (char_byte, line_end)
//  out       output     o_out_valid / i_out_stall t_out_item (4 fields)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one input beat per cycle when each beat yields at most one result and i_out_stall is low
// a beat with n results holds the back end until all n have gone out; the 4-entry
// command queue lets the input keep flowing meanwhile, and o_in_stall rises only
// when that queue is full
// synchronous active-low reset clears control state and all config registers
`include "stream_replace_first_match_defines.svh"

module stream_replace_first_match import srfm_pkg::*; #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int WIN_W = MAX_PATTERN * 8;
    localparam int Q_W   = $bits(t_cmd_ctl) + WIN_W;

    logic [CFG_DAT_W-1:0] r_pattern_bytes, r_replacement_bytes;
    logic [CNT_W-1:0]     r_pattern_length, r_replacement_length;

    logic             in_accept, cfg_we;
    t_cmd_ctl         cmd_ctl, head_ctl;
    logic [WIN_W-1:0] cmd_win, head_win;
    logic [Q_W-1:0]   head_data;
    logic             q_nempty, q_full, q_pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes      <= '0;
            r_pattern_length     <= '0;
            r_replacement_bytes  <= '0;
            r_replacement_length <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_BYTES:      r_pattern_bytes      <= i_cfg_data;
                REG_PATTERN_LENGTH:     r_pattern_length     <= i_cfg_data[CNT_W-1:0];
                REG_REPLACEMENT_BYTES:  r_replacement_bytes  <= i_cfg_data;
                REG_REPLACEMENT_LENGTH: r_replacement_length <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    srfm_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_item           (i_in_item),
        .i_pattern_bytes  (r_pattern_bytes),
        .i_pattern_length (r_pattern_length),
        .o_cmd_ctl        (cmd_ctl),
        .o_cmd_win        (cmd_win)
    );

    srfm_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_data   ({cmd_ctl, cmd_win}),
        .i_pop    (q_pop),
        .o_data   (head_data),
        .o_nempty (q_nempty),
        .o_full   (q_full)
    );

    assign head_ctl = head_data[Q_W-1 -: $bits(t_cmd_ctl)];
    assign head_win = head_data[WIN_W-1:0];

    srfm_back #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_head_valid         (q_nempty),
        .i_head_ctl           (head_ctl),
        .i_head_win           (head_win),
        .i_replacement_bytes  (r_replacement_bytes),
        .i_replacement_length (r_replacement_length),
        .o_pop                (q_pop),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_out_item           (o_out_item)
    );

    // a beat without a character is always a closing line end
    `SRFM_ASSERT_IMP(a_bare_is_line_end, o_out_valid && !o_out_item.has_byte,
        o_out_item.out_line_end && o_out_item.run_last)
    // line end closes the run of its input beat
    `SRFM_ASSERT_IMP(a_line_end_closes_run, o_out_valid && o_out_item.out_line_end,
        o_out_item.run_last)
    // back end never consumes a command that is not there
    `SRFM_ASSERT_IMP(a_pop_has_head, q_pop, q_nempty)
    // queue stays empty until the front end pushes
    `SRFM_ASSERT_NEXT(a_empty_holds, !q_nempty && !in_accept, !q_nempty)

endmodule
